// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the sorted keymap table engine.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent on the same clock edge.
`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Checks that an antecedent implies a consequent on the following clock edge.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/skte_pkg.sv =====
// Package for the sorted keymap table engine: item structs, mode codes and
// controller-to-datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package skte_pkg;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] scancode;
    logic [15:0] keycode;
    logic [15:0] protocol;
    logic [8:0]  index;
    logic [4:0]  max_matches;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [15:0] found_keycode;
    logic [31:0] found_scancode;
    logic [15:0] found_protocol;
    logic [8:0]  entry_index;
    logic [4:0]  match_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] scancode;
    logic [15:0] keycode;
    logic [15:0] protocol;
  } entry_t;

  localparam logic [2:0] MODE_SET    = 3'd0;
  localparam logic [2:0] MODE_FIND   = 3'd1;
  localparam logic [2:0] MODE_LOOKUP = 3'd2;
  localparam logic [2:0] MODE_READ   = 3'd3;
  localparam logic [2:0] MODE_CHECK  = 3'd4;
  localparam logic [2:0] MODE_CLEAR  = 3'd5;

  localparam logic [15:0] INSERT_CODE = 16'd768;

  // Pointer operations.
  localparam logic [2:0] PTR_HOLD  = 3'd0;
  localparam logic [2:0] PTR_INC   = 3'd1;
  localparam logic [2:0] PTR_DEC   = 3'd2;
  localparam logic [2:0] PTR_ZERO  = 3'd3;
  localparam logic [2:0] PTR_IDX   = 3'd4;
  localparam logic [2:0] PTR_CNTM1 = 3'd5;
  localparam logic [2:0] PTR_CHK   = 3'd6;

  // Result kinds built by the datapath.
  localparam logic [2:0] RK_FAIL  = 3'd0;
  localparam logic [2:0] RK_CLEAR = 3'd1;
  localparam logic [2:0] RK_ENTRY = 3'd2;
  localparam logic [2:0] RK_UPD   = 3'd3;
  localparam logic [2:0] RK_INS   = 3'd4;

  typedef struct packed {
    logic       req_load;
    logic       n_clr;
    logic       n_inc;
    logic [2:0] ptr_op;
    logic       ins_cap;
    logic       wr_upd;
    logic       wr_shift;
    logic       wr_new;
    logic       count_clr;
    logic       count_inc;
    logic       res_load;
    logic [2:0] res_kind;
    logic       res_last;
    logic       res_final;
    logic       out_load;
  } skte_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       chk_valid;
    logic       sc_ge;
    logic       sc_eq;
    logic       kc_eq;
    logic       pr_eq;
    logic       full;
    logic       at_ins;
    logic       idx_ok;
    logic       lim_zero;
    logic       n_last;
    logic       out_free;
  } skte_stat_t;

endpackage

// ===== sv/sorted_keymap_table_engine.sv =====
// Sorted keymap table engine, top level: a table of (scancode, keycode,
// protocol) entries kept in ascending scancode order in one single-port-read
// memory, walked one entry per clock except while a find waits to hand off a
// held match. Set, find, lookup and check walk the entries held; an insert
// walks to the insertion point and then shifts the tail up one entry per
// cycle. Find revisits a matching entry after handing off the one it held,
// and a result that waits to be handed off holds the engine while the output
// is stalled. Read by index reads the one entry named, or fails without a
// read when the index is past the last entry; clear and unused modes answer
// without a walk. The engine works on one item at a time and stalls its
// input while busy; it can still accept the next item while a finished result
// waits in the output register. Find emits one item per match up to its match
// limit, holding each until the next match or the end of the walk decides its
// last flag; the match that reaches the limit goes out marked last. The table
// holds at most TABLE_DEPTH - 1 entries; entries never written are never read.
// Depends on skte_pkg, skte_ctrl, skte_dp and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_keymap_table_engine import skte_pkg::*; #(
  parameter int TABLE_DEPTH      = 512,
  parameter int MAX_FIND_RESULTS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  in_item_t  req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output out_item_t rsp
);

  skte_cmd_t  cmd;
  skte_stat_t st;

  // The controller sequences each item; the datapath owns all storage.
  skte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  skte_dp #(
    .TABLE_DEPTH      (TABLE_DEPTH),
    .MAX_FIND_RESULTS (MAX_FIND_RESULTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_in    (req),
    .cmd       (cmd),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Once an item is taken, the engine must be busy on the next cycle.
  `CHK_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
  // A result is never loaded over one that is still stalled.
  `CHK_IMPL(a_no_overwrite, cmd.out_load, st.out_free)
  // An insert never grows a full table.
  `CHK_IMPL(a_no_overfill, cmd.count_inc, !st.full)
  // Shifting and placing the new entry never share a cycle.
  `CHK_IMPL(a_one_write, cmd.wr_shift, !cmd.wr_new && !cmd.wr_upd)

endmodule

// ===== sv/skte_dp.sv =====
// Datapath of the sorted keymap table engine: entry memory, pointers,
// counters, result staging and the output register. Uses skte_pkg.
`timescale 1ns / 1ps

module skte_dp import skte_pkg::*; #(
  parameter int TABLE_DEPTH      = 512,
  parameter int MAX_FIND_RESULTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   req_in,
  input  skte_cmd_t  cmd,
  output skte_stat_t st,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output out_item_t  rsp
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(TABLE_DEPTH - 1);

  entry_t          mem [TABLE_DEPTH];
  entry_t          rdata;
  entry_t          wdata;
  entry_t          new_entry;
  logic [AW-1:0]   ptr;
  logic [AW-1:0]   ptr_next;
  logic [AW-1:0]   chk;
  logic [AW-1:0]   count;
  logic [AW-1:0]   ins;
  logic [AW-1:0]   waddr;
  logic            we;
  in_item_t        req;
  logic [4:0]      n;
  logic [4:0]      n_plus;
  logic [4:0]      lim;
  out_item_t       res;
  out_item_t       res_new;

  assign new_entry = '{scancode: req.scancode, keycode: req.keycode, protocol: req.protocol};
  assign n_plus    = n + 5'd1;
  assign lim       = (int'(req.max_matches) > MAX_FIND_RESULTS) ?
                     5'(MAX_FIND_RESULTS) : req.max_matches;

  // One write port, one registered read port.
  always_comb begin
    we    = cmd.wr_shift | cmd.wr_new | cmd.wr_upd;
    wdata = new_entry;
    waddr = chk;
    if (cmd.wr_shift) begin
      waddr = chk + 1'b1;
      wdata = rdata;
    end else if (cmd.wr_new) begin
      waddr = ins;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[ptr];
  end

  always_comb begin
    case (cmd.ptr_op)
      PTR_INC:   ptr_next = ptr + 1'b1;
      PTR_DEC:   ptr_next = ptr - 1'b1;
      PTR_ZERO:  ptr_next = '0;
      PTR_IDX:   ptr_next = AW'(req.index);
      PTR_CNTM1: ptr_next = count - 1'b1;
      PTR_CHK:   ptr_next = chk;
      default:   ptr_next = ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    chk <= ptr;
    if (cmd.req_load) begin
      req <= req_in;
    end
    if (cmd.ins_cap) begin
      ins <= st.chk_valid ? chk : count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      n     <= '0;
    end else begin
      if (cmd.count_clr) begin
        count <= '0;
      end else if (cmd.count_inc) begin
        count <= count + 1'b1;
      end
      if (cmd.n_clr) begin
        n <= '0;
      end else if (cmd.n_inc) begin
        n <= n_plus;
      end
    end
  end

  always_comb begin
    res_new      = '0;
    res_new.last = 1'b1;
    case (cmd.res_kind)
      RK_FAIL: begin
        res_new.status = 1'b1;
      end
      RK_CLEAR: begin
        res_new.status = 1'b0;
      end
      RK_ENTRY: begin
        res_new.found_keycode  = rdata.keycode;
        res_new.found_scancode = rdata.scancode;
        res_new.found_protocol = rdata.protocol;
        res_new.entry_index    = 9'(chk);
        res_new.match_count    = (req.mode == MODE_FIND) ? n_plus : 5'd0;
        res_new.last           = cmd.res_last;
      end
      RK_UPD: begin
        res_new.found_keycode  = rdata.keycode;
        res_new.found_scancode = req.scancode;
        res_new.entry_index    = 9'(chk);
      end
      RK_INS: begin
        res_new.found_keycode  = INSERT_CODE;
        res_new.found_scancode = req.scancode;
        res_new.entry_index    = 9'(ins);
      end
      default: begin
        res_new.status = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res <= res_new;
    end else if (cmd.res_final) begin
      res.last <= 1'b1;
    end
    if (cmd.out_load) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    st.mode      = req.mode;
    st.chk_valid = chk < count;
    st.sc_ge     = rdata.scancode >= req.scancode;
    st.sc_eq     = rdata.scancode == req.scancode;
    st.kc_eq     = rdata.keycode == req.keycode;
    st.pr_eq     = rdata.protocol == req.protocol;
    st.full      = count == LastAddr;
    st.at_ins    = chk == ins;
    st.idx_ok    = 32'(req.index) < 32'(count);
    st.lim_zero  = lim == 5'd0;
    st.n_last    = n_plus == lim;
    st.out_free  = !rsp_valid || !rsp_stall;
  end

endmodule

// ===== sv/skte_ctrl.sv =====
// Controller state machine of the sorted keymap table engine.
// Drives skte_cmd_t commands from skte_stat_t status; uses skte_pkg.
`timescale 1ns / 1ps

module skte_ctrl import skte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  skte_stat_t st,
  output skte_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_PRIME  = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_FEMIT  = 4'd4;
  localparam logic [3:0] S_SPRIME = 4'd5;
  localparam logic [3:0] S_SHIFT  = 4'd6;
  localparam logic [3:0] S_INS    = 4'd7;
  localparam logic [3:0] S_RD     = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       pend;
  logic       pend_next;

  assign req_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    pend_next  = pend;
    case (state)
      S_IDLE: begin
        pend_next = 1'b0;
        if (req_valid) begin
          cmd.req_load = 1'b1;
          cmd.n_clr    = 1'b1;
          state_next   = S_DISP;
        end
      end
      S_DISP: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = RK_FAIL;
        state_next   = S_EMIT;
        case (st.mode)
          MODE_SET, MODE_LOOKUP, MODE_CHECK: begin
            cmd.res_load = 1'b0;
            cmd.ptr_op   = PTR_ZERO;
            state_next   = S_PRIME;
          end
          MODE_FIND: begin
            if (!st.lim_zero) begin
              cmd.res_load = 1'b0;
              cmd.ptr_op   = PTR_ZERO;
              state_next   = S_PRIME;
            end
          end
          MODE_READ: begin
            if (st.idx_ok) begin
              cmd.res_load = 1'b0;
              cmd.ptr_op   = PTR_IDX;
              state_next   = S_PRIME;
            end
          end
          MODE_CLEAR: begin
            cmd.count_clr = 1'b1;
            cmd.res_kind  = RK_CLEAR;
          end
          default: begin
            cmd.res_kind = RK_FAIL;
          end
        endcase
      end
      S_PRIME: begin
        cmd.ptr_op = PTR_INC;
        state_next = (st.mode == MODE_READ) ? S_RD : S_SCAN;
      end
      S_RD: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = RK_ENTRY;
        cmd.res_last = 1'b1;
        state_next   = S_EMIT;
      end
      S_SCAN: begin
        cmd.ptr_op = PTR_INC;
        case (st.mode)
          MODE_SET: begin
            if (!st.chk_valid || st.sc_ge) begin
              cmd.ins_cap = 1'b1;
              cmd.ptr_op  = PTR_HOLD;
              if (st.chk_valid && st.sc_eq) begin
                cmd.wr_upd   = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_kind = RK_UPD;
                state_next   = S_EMIT;
              end else if (st.full) begin
                cmd.res_load = 1'b1;
                cmd.res_kind = RK_FAIL;
                state_next   = S_EMIT;
              end else if (!st.chk_valid) begin
                state_next = S_INS;
              end else begin
                cmd.ptr_op = PTR_CNTM1;
                state_next = S_SPRIME;
              end
            end
          end
          MODE_LOOKUP, MODE_CHECK: begin
            if (!st.chk_valid) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = RK_FAIL;
              state_next   = S_EMIT;
            end else if ((st.mode == MODE_LOOKUP) ? st.sc_eq : st.kc_eq) begin
              cmd.res_load = 1'b1;
              cmd.res_kind = RK_ENTRY;
              cmd.res_last = 1'b1;
              state_next   = S_EMIT;
            end
          end
          MODE_FIND: begin
            if (!st.chk_valid) begin
              if (pend) begin
                cmd.res_final = 1'b1;
              end else begin
                cmd.res_load = 1'b1;
                cmd.res_kind = RK_FAIL;
              end
              state_next = S_EMIT;
            end else if (st.kc_eq && st.pr_eq) begin
              if (pend) begin
                // Hand off the held match first, then revisit this entry.
                cmd.ptr_op = PTR_CHK;
                state_next = S_FEMIT;
              end else begin
                cmd.res_load = 1'b1;
                cmd.res_kind = RK_ENTRY;
                cmd.n_inc    = 1'b1;
                if (st.n_last) begin
                  cmd.res_last = 1'b1;
                  state_next   = S_EMIT;
                end else begin
                  pend_next = 1'b1;
                end
              end
            end
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RK_FAIL;
            state_next   = S_EMIT;
          end
        endcase
      end
      S_FEMIT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          pend_next    = 1'b0;
          state_next   = S_PRIME;
        end
      end
      S_SPRIME: begin
        cmd.ptr_op = PTR_DEC;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.wr_shift = 1'b1;
        cmd.ptr_op   = PTR_DEC;
        if (st.at_ins) begin
          state_next = S_INS;
        end
      end
      S_INS: begin
        cmd.wr_new    = 1'b1;
        cmd.count_inc = 1'b1;
        cmd.res_load  = 1'b1;
        cmd.res_kind  = RK_INS;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== dv/tb.sv =====
// Testbench for the sorted keymap table engine: drives set, find, lookup, read,
// check, clear and unused-mode items and compares every result item with a local
// table model. Depends on skte_pkg and the sorted_keymap_table_engine RTL.
`timescale 1ns / 1ps

module tb;
  import skte_pkg::*;

  localparam int DEPTH = 512;
  localparam int CAPACITY = DEPTH - 1;
  localparam int FIND_CAP = 16;
  localparam int FILL_COUNT = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  in_item_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  out_item_t rsp;

  always #2 clk = ~clk;

  sorted_keymap_table_engine uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // Local copy of the table, kept sorted by scancode.
  logic [31:0] tbl_sc[DEPTH];
  logic [15:0] tbl_kc[DEPTH];
  logic [15:0] tbl_pr[DEPTH];
  int tbl_count = 0;

  out_item_t pending_results[$];
  int mismatches = 0;
  bit hold_off = 1'b0;

  // Small pools so that set updates, find hits and check hits are common.
  logic [31:0] known_sc[$];

  function automatic out_item_t empty_result(logic st);
    out_item_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic out_item_t entry_result(int i, int cnt, logic lst);
    out_item_t r;
    r = '0;
    r.found_keycode = tbl_kc[i];
    r.found_scancode = tbl_sc[i];
    r.found_protocol = tbl_pr[i];
    r.entry_index = i[8:0];
    r.match_count = cnt[4:0];
    r.last = lst;
    return r;
  endfunction

  // Applies one item to the local table and queues the results it causes.
  task automatic predict_table_op(in_item_t it);
    int i, j, n, lim;
    out_item_t r;
    out_item_t hits[$];
    case (it.mode)
      MODE_SET: begin
        i = 0;
        while (i < tbl_count && tbl_sc[i] < it.scancode) i++;
        if (i < tbl_count && tbl_sc[i] == it.scancode) begin
          r = empty_result(1'b0);
          r.found_keycode = tbl_kc[i];
          r.found_scancode = it.scancode;
          r.entry_index = i[8:0];
          tbl_kc[i] = it.keycode;
          tbl_pr[i] = it.protocol;
          pending_results.push_back(r);
        end else if (tbl_count >= CAPACITY) begin
          pending_results.push_back(empty_result(1'b1));
        end else begin
          for (j = tbl_count; j > i; j--) begin
            tbl_sc[j] = tbl_sc[j-1];
            tbl_kc[j] = tbl_kc[j-1];
            tbl_pr[j] = tbl_pr[j-1];
          end
          tbl_sc[i] = it.scancode;
          tbl_kc[i] = it.keycode;
          tbl_pr[i] = it.protocol;
          tbl_count++;
          r = empty_result(1'b0);
          r.found_keycode = INSERT_CODE;
          r.found_scancode = it.scancode;
          r.entry_index = i[8:0];
          pending_results.push_back(r);
        end
      end
      MODE_FIND: begin
        lim = (it.max_matches > FIND_CAP) ? FIND_CAP : it.max_matches;
        n = 0;
        for (i = 0; i < tbl_count && n < lim; i++) begin
          if (tbl_pr[i] == it.protocol && tbl_kc[i] == it.keycode) begin
            n++;
            hits.push_back(entry_result(i, n, 1'b0));
          end
        end
        if (n == 0) begin
          pending_results.push_back(empty_result(1'b1));
        end else begin
          hits[n-1].last = 1'b1;
          foreach (hits[k]) pending_results.push_back(hits[k]);
        end
      end
      MODE_LOOKUP: begin
        r = empty_result(1'b1);
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_sc[i] == it.scancode) begin
            r = entry_result(i, 0, 1'b1);
            break;
          end
        end
        pending_results.push_back(r);
      end
      MODE_READ: begin
        if (it.index < tbl_count) pending_results.push_back(entry_result(it.index, 0, 1'b1));
        else pending_results.push_back(empty_result(1'b1));
      end
      MODE_CHECK: begin
        r = empty_result(1'b1);
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_kc[i] == it.keycode) begin
            r = entry_result(i, 0, 1'b1);
            break;
          end
        end
        pending_results.push_back(r);
      end
      MODE_CLEAR: begin
        tbl_count = 0;
        pending_results.push_back(empty_result(1'b0));
      end
      default: pending_results.push_back(empty_result(1'b1));
    endcase
  endtask

  // Burst/gap pacing for the sender.
  int burst_left = 0;

  // Offers one item and holds it until the block accepts it. Valid stays up
  // after acceptance until the next item or the next gap replaces it.
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    req <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_table_op(it);
  endtask

  function automatic in_item_t make_item(logic [2:0] m, logic [31:0] sc, logic [15:0] kc,
                                         logic [15:0] pr, logic [8:0] ix, logic [4:0] mm);
    in_item_t it;
    it.mode = m;
    it.scancode = sc;
    it.keycode = kc;
    it.protocol = pr;
    it.index = ix;
    it.max_matches = mm;
    return it;
  endfunction

  // Receiver stall pattern; a long hold-off can be forced from the test.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_off) begin
      rsp_stall <= 1'b1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: rsp_stall <= 1'b1;
        default: rsp_stall <= 1'b0;
      endcase
    end
  end

  // Result checker: every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", rsp);
      end else begin
        exp_r = pending_results.pop_front();
        if (rsp !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_r, rsp);
        end
      end
    end
  end

  // Extremes of fields, every mode, insert at head/tail, update, absent cases.
  task automatic test_directed();
    send_item(make_item(MODE_LOOKUP, 32'd5, 16'd0, 16'd0, 9'd0, 5'd0));
    send_item(make_item(MODE_READ, 32'd0, 16'd0, 16'd0, 9'd511, 5'd0));
    send_item(make_item(MODE_FIND, 32'd0, 16'd1, 16'd1, 9'd0, 5'd16));
    send_item(make_item(MODE_CHECK, 32'd0, 16'hFFFF, 16'd0, 9'd0, 5'd0));
    send_item(make_item(MODE_SET, 32'd100, 16'd7, 16'd3, 9'd0, 5'd0));
    send_item(make_item(MODE_SET, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 9'd0, 5'd0));
    send_item(make_item(MODE_SET, 32'd0, 16'd7, 16'd3, 9'd0, 5'd0));
    send_item(make_item(MODE_SET, 32'd50, 16'd7, 16'd3, 9'd0, 5'd0));
    send_item(make_item(MODE_SET, 32'd50, 16'd9, 16'd3, 9'd0, 5'd0));
    send_item(make_item(MODE_SET, 32'd50, 16'd7, 16'd3, 9'd0, 5'd0));
    send_item(make_item(MODE_FIND, 32'd0, 16'd7, 16'd3, 9'd0, 5'd0));
    send_item(make_item(MODE_FIND, 32'd0, 16'd7, 16'd3, 9'd0, 5'd2));
    send_item(make_item(MODE_FIND, 32'd0, 16'd7, 16'd3, 9'd0, 5'd31));
    send_item(make_item(MODE_LOOKUP, 32'hFFFF_FFFF, 16'd0, 16'd0, 9'd0, 5'd0));
    send_item(make_item(MODE_READ, 32'd0, 16'd0, 16'd0, 9'd3, 5'd0));
    send_item(make_item(MODE_READ, 32'd0, 16'd0, 16'd0, 9'd4, 5'd0));
    send_item(make_item(MODE_CHECK, 32'd0, 16'hFFFF, 16'd0, 9'd0, 5'd0));
    send_item(make_item(3'd6, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 9'h1FF, 5'h1F));
    send_item(make_item(3'd7, 32'd0, 16'd0, 16'd0, 9'd0, 5'd0));
    send_item(make_item(MODE_CLEAR, 32'd0, 16'd0, 16'd0, 9'd0, 5'd0));
    send_item(make_item(MODE_READ, 32'd0, 16'd0, 16'd0, 9'd0, 5'd0));
  endtask

  // Fills a large part of the table with ascending keys, then inserts near the
  // head so the shift walks almost every entry held, then reads, finds and clears.
  task automatic test_bulk_fill();
    int k;
    for (k = 0; k < FILL_COUNT; k++)
      send_item(make_item(MODE_SET, 32'(k * 3 + 1), k[15:0], 16'd1, 9'd0, 5'd0));
    send_item(make_item(MODE_SET, 32'd2, 16'd1, 16'd1, 9'd0, 5'd0));
    send_item(make_item(MODE_SET, 32'd4, 16'd9, 16'd1, 9'd0, 5'd0));
    send_item(make_item(MODE_READ, 32'd0, 16'd0, 16'd0, 9'd200, 5'd0));
    send_item(make_item(MODE_FIND, 32'd0, 16'd5, 16'd1, 9'd0, 5'd16));
    send_item(make_item(MODE_CLEAR, 32'd0, 16'd0, 16'd0, 9'd0, 5'd0));
  endtask

  function automatic logic [31:0] pick_scancode();
    if (known_sc.size() > 0 && $urandom_range(0, 2) == 0)
      return known_sc[$urandom_range(0, known_sc.size() - 1)];
    if ($urandom_range(0, 1)) return $urandom;
    return $urandom_range(0, 63);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int sel;
    it = '0;
    sel = $urandom_range(0, 99);
    if (sel < 45) it.mode = MODE_SET;
    else if (sel < 62) it.mode = MODE_FIND;
    else if (sel < 74) it.mode = MODE_LOOKUP;
    else if (sel < 84) it.mode = MODE_READ;
    else if (sel < 93) it.mode = MODE_CHECK;
    else if (sel < 96) it.mode = MODE_CLEAR;
    else it.mode = 3'($urandom_range(6, 7));
    it.scancode = pick_scancode();
    it.keycode = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3));
    it.protocol = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1));
    it.index = $urandom_range(0, 1) ? 9'($urandom) : 9'($urandom_range(0, 40));
    it.max_matches = 5'($urandom_range(0, 31));
    return it;
  endfunction

  task automatic test_random_ops();
    in_item_t it;
    repeat (135) begin
      it = random_item();
      if (it.mode == MODE_SET) known_sc.push_back(it.scancode);
      send_item(it);
    end
  endtask

  // The receiver holds off while items keep coming, so the engine backs up.
  task automatic test_output_backpressure();
    in_item_t it;
    fork
      begin
        int c;
        hold_off = 1'b1;
        for (c = 0; c < 400; c++) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (20) begin
        it = random_item();
        send_item(it);
      end
    join
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_output_backpressure();
    test_random_ops();
    test_bulk_fill();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sorted_keymap_table_engine.f =====
+incdir+sv
sv/skte_pkg.sv
sv/skte_dp.sv
sv/skte_ctrl.sv
sv/sorted_keymap_table_engine.sv
dv/tb.sv
